>>> sv/sssbd_pkg.sv
package sssbd_pkg;

	// Display geometry.
	localparam int DIGIT_COUNT = 4;

	// One decimal digit as held in the store and driven on the BCD pins.
	typedef logic [3:0] bcd_t;
	typedef bcd_t [DIGIT_COUNT-1:0] digit_store_t;
	typedef logic [DIGIT_COUNT-1:0] enable_t;
	typedef logic [15:0] elapsed_t;
	typedef logic [14:0] period_t;
	typedef logic [1:0] position_t;

	// Input item actions.
	typedef enum logic [1:0] {
		ACT_TICK        = 2'd0,
		ACT_LOAD_NUMBER = 2'd1,
		ACT_LOAD_DIGIT  = 2'd2
	} action_t;

	// Display modes.
	typedef enum logic [1:0] {
		MODE_PLAIN       = 2'd0,
		MODE_DIGIT_BLINK = 2'd1,
		MODE_WHOLE_BLINK = 2'd2
	} mode_t;

	// Configuration register indexes.
	localparam logic [1:0] REG_DISPLAY_MODE      = 2'd0;
	localparam logic [1:0] REG_SELECTED_DIGIT    = 2'd1;
	localparam logic [1:0] REG_SCAN_PERIOD       = 2'd2;
	localparam logic [1:0] REG_BLINK_HALF_PERIOD = 2'd3;

	// Reset values of the configuration registers.
	localparam period_t SCAN_PERIOD_RESET       = 15'd5;
	localparam period_t BLINK_HALF_PERIOD_RESET = 15'd500;

	localparam enable_t  ALL_OFF      = 4'hF;
	localparam elapsed_t COUNT_MAX    = 16'hFFFF;
	localparam bcd_t     BCD_LIMIT    = 4'd10;
	localparam logic [13:0] NUMBER_LIMIT = 14'd10000;

	// Reciprocal multipliers for division of values below 10000 by 10, 100, 1000.
	localparam logic [29:0] DIV10_MUL     = 30'd52429;
	localparam int          DIV10_SHIFT   = 19;
	localparam logic [29:0] DIV100_MUL    = 30'd5243;
	localparam int          DIV100_SHIFT  = 19;
	localparam logic [29:0] DIV1000_MUL   = 30'd8389;
	localparam int          DIV1000_SHIFT = 23;

endpackage

>>> sv/sssbd_bcd_split.sv
module sssbd_bcd_split (
	input  logic [13:0]                 number,
	output logic                        in_range,
	output sssbd_pkg::digit_store_t     digits
);

	logic [29:0] prod10;
	logic [29:0] prod100;
	logic [29:0] prod1000;
	logic [9:0]  q10;
	logic [6:0]  q100;
	logic [3:0]  q1000;
	logic [13:0] tens_of_q10;
	logic [9:0]  tens_of_q100;
	logic [6:0]  tens_of_q1000;

	// Independent reciprocal multiplications give the number over 10, 100 and 1000.
	assign prod10   = 30'(number) * sssbd_pkg::DIV10_MUL;
	assign prod100  = 30'(number) * sssbd_pkg::DIV100_MUL;
	assign prod1000 = 30'(number) * sssbd_pkg::DIV1000_MUL;

	assign q10   = prod10[sssbd_pkg::DIV10_SHIFT +: 10];
	assign q100  = prod100[sssbd_pkg::DIV100_SHIFT +: 7];
	assign q1000 = prod1000[sssbd_pkg::DIV1000_SHIFT +: 4];

	// Times ten by shift and add, then each digit is the remainder of its quotient.
	assign tens_of_q10   = 14'({q10, 3'b000}) + 14'({q10, 1'b0});
	assign tens_of_q100  = 10'({q100, 3'b000}) + 10'({q100, 1'b0});
	assign tens_of_q1000 = 7'({q1000, 3'b000}) + 7'({q1000, 1'b0});

	// Digit 0 is the leftmost (thousands).
	assign digits[3] = 4'(number - tens_of_q10);
	assign digits[2] = 4'(q10 - tens_of_q100);
	assign digits[1] = 4'(q100 - tens_of_q1000);
	assign digits[0] = q1000;

	assign in_range = (number < sssbd_pkg::NUMBER_LIMIT);

endmodule

>>> sv/seven_segment_scan_blink_driver_unit.sv
// Four-digit multiplexed BCD display driver.
// Input channel (item_valid/item_stall) carries one item per transfer: a
// millisecond tick, a whole-number load (up to 9999) or a single-digit load.
// Every accepted item yields exactly one result transfer on the output
// channel (result_valid/result_stall): the active-low digit enables, the BCD
// code and a flag set when a number load was out of range and dropped.
// An item is registered in the input stage at acceptance, and its result is
// registered in the result register when that stage moves on, which a
// receiver stall can hold off. A new item can be taken in every cycle while
// the receiver does not stall; throughput is one item per cycle, set by the
// single result register that closes the state update of each item.
// When the receiver stalls, the result holds and the input stage fills; the
// input then stalls until the result is taken.
// Configuration, written via cfg_write_en/cfg_index/cfg_data, takes effect for
// the next item; the user writes it only while the block is idle (not enforced).
// Reset clears the digit store, counters and scan positions, turns all
// digits off (enables all ones), sets the display dark in blink-all mode,
// and loads mode 0, digit 0, scan period 5 and blink half period 500.
module seven_segment_scan_blink_driver_unit (
	input  logic                    clk,
	input  logic                    arst_n,

	input  logic                    cfg_write_en,
	input  logic [1:0]              cfg_index,
	input  logic [14:0]             cfg_data,

	input  logic                    item_valid,
	output logic                    item_stall,
	input  logic [1:0]              action,
	input  logic [13:0]             number,
	input  logic [1:0]              digit_index,
	input  logic [3:0]              digit_value,

	output logic                    result_valid,
	input  logic                    result_stall,
	output logic [3:0]              digit_enable_n,
	output logic [3:0]              bcd_code,
	output logic                    load_ignored
);

	// Configuration registers.
	sssbd_pkg::mode_t     display_mode_q;
	sssbd_pkg::position_t selected_digit_q;
	sssbd_pkg::period_t   scan_period_q;
	sssbd_pkg::period_t   blink_half_period_q;

	// Input stage.
	logic                 valid_s1;
	sssbd_pkg::action_t   action_s1;
	logic [13:0]          number_s1;
	sssbd_pkg::position_t digit_index_s1;
	sssbd_pkg::bcd_t      digit_value_s1;

	// Display state.
	sssbd_pkg::digit_store_t store_q;
	sssbd_pkg::position_t    scan_pos_q;
	sssbd_pkg::position_t    blink_pos_q;
	sssbd_pkg::elapsed_t     scan_elapsed_q;
	sssbd_pkg::elapsed_t     digit_blink_elapsed_q;
	sssbd_pkg::elapsed_t     whole_blink_elapsed_q;
	logic                    dark_q;
	logic                    display_on_q;
	sssbd_pkg::enable_t      enable_q;
	sssbd_pkg::bcd_t         bcd_q;
	logic                    ignored_q;
	logic                    result_valid_q;

	// Next-state values.
	sssbd_pkg::digit_store_t store_d;
	sssbd_pkg::position_t    scan_pos_d;
	sssbd_pkg::position_t    blink_pos_d;
	sssbd_pkg::elapsed_t     scan_elapsed_d;
	sssbd_pkg::elapsed_t     digit_blink_elapsed_d;
	sssbd_pkg::elapsed_t     whole_blink_elapsed_d;
	logic                    dark_d;
	logic                    display_on_d;
	sssbd_pkg::enable_t      enable_d;
	sssbd_pkg::bcd_t         bcd_d;
	logic                    ignored_d;

	logic                    advance;
	logic                    number_in_range;
	sssbd_pkg::digit_store_t split_digits;
	sssbd_pkg::position_t    read_pos;
	sssbd_pkg::bcd_t         read_digit;

	// The stage moves on whenever the result register is empty or being drained.
	assign advance    = valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall = valid_s1 && !advance;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			display_mode_q      <= sssbd_pkg::MODE_PLAIN;
			selected_digit_q    <= '0;
			scan_period_q       <= sssbd_pkg::SCAN_PERIOD_RESET;
			blink_half_period_q <= sssbd_pkg::BLINK_HALF_PERIOD_RESET;
		end else if (cfg_write_en) begin
			case (cfg_index)
				sssbd_pkg::REG_DISPLAY_MODE: begin
					display_mode_q <= sssbd_pkg::mode_t'(cfg_data[1:0]);
				end
				sssbd_pkg::REG_SELECTED_DIGIT: begin
					selected_digit_q <= cfg_data[1:0];
				end
				sssbd_pkg::REG_SCAN_PERIOD: begin
					scan_period_q <= cfg_data;
				end
				sssbd_pkg::REG_BLINK_HALF_PERIOD: begin
					blink_half_period_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// Input register: takes a transfer whenever the stage is free or moving on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			action_s1      <= sssbd_pkg::action_t'(action);
			number_s1      <= number;
			digit_index_s1 <= digit_index;
			digit_value_s1 <= digit_value;
		end
	end

	sssbd_bcd_split u_split (
		.number   (number_s1),
		.in_range (number_in_range),
		.digits   (split_digits)
	);

	// The scanned digit comes from one of the two scan positions.
	assign read_pos   = (display_mode_q == sssbd_pkg::MODE_DIGIT_BLINK) ? blink_pos_q : scan_pos_q;
	assign read_digit = store_q[read_pos];

	// Per-item state update.
	always_comb begin
		store_d               = store_q;
		scan_pos_d            = scan_pos_q;
		blink_pos_d           = blink_pos_q;
		scan_elapsed_d        = scan_elapsed_q;
		digit_blink_elapsed_d = digit_blink_elapsed_q;
		whole_blink_elapsed_d = whole_blink_elapsed_q;
		dark_d                = dark_q;
		display_on_d          = display_on_q;
		enable_d              = enable_q;
		bcd_d                 = bcd_q;
		ignored_d             = 1'b0;

		case (action_s1)
			sssbd_pkg::ACT_TICK: begin
				// All elapsed counters advance, saturating at the top.
				if (scan_elapsed_q != sssbd_pkg::COUNT_MAX) begin
					scan_elapsed_d = scan_elapsed_q + 16'd1;
				end
				if (digit_blink_elapsed_q != sssbd_pkg::COUNT_MAX) begin
					digit_blink_elapsed_d = digit_blink_elapsed_q + 16'd1;
				end
				if (whole_blink_elapsed_q != sssbd_pkg::COUNT_MAX) begin
					whole_blink_elapsed_d = whole_blink_elapsed_q + 16'd1;
				end

				case (display_mode_q)
					sssbd_pkg::MODE_DIGIT_BLINK: begin
						// Scan every tick; the selected digit is lit only in its bright phase.
						if (read_digit < sssbd_pkg::BCD_LIMIT) begin
							bcd_d = read_digit;
						end
						enable_d = sssbd_pkg::ALL_OFF;
						if (blink_pos_q == selected_digit_q) begin
							if (!dark_q) begin
								enable_d = ~(4'b0001 << blink_pos_q);
							end
							if (digit_blink_elapsed_d > {1'b0, blink_half_period_q}) begin
								dark_d                = !dark_q;
								digit_blink_elapsed_d = '0;
							end
						end else begin
							enable_d = ~(4'b0001 << blink_pos_q);
						end
						blink_pos_d = blink_pos_q + 2'd1;
					end
					sssbd_pkg::MODE_PLAIN, sssbd_pkg::MODE_WHOLE_BLINK: begin
						// Whole-display blink toggles first and darkens when turning off.
						if (display_mode_q == sssbd_pkg::MODE_WHOLE_BLINK &&
						    whole_blink_elapsed_d > {1'b0, blink_half_period_q}) begin
							if (display_on_q) begin
								enable_d = sssbd_pkg::ALL_OFF;
							end
							display_on_d          = !display_on_q;
							whole_blink_elapsed_d = '0;
						end
						// Plain scan step, also used while the whole display is on.
						if ((display_mode_q == sssbd_pkg::MODE_PLAIN || display_on_d) &&
						    scan_elapsed_d > {1'b0, scan_period_q}) begin
							enable_d = ~(4'b0001 << scan_pos_q);
							if (read_digit < sssbd_pkg::BCD_LIMIT) begin
								bcd_d = read_digit;
							end
							scan_pos_d     = scan_pos_q + 2'd1;
							scan_elapsed_d = '0;
						end
					end
					default: begin
					end
				endcase
			end
			sssbd_pkg::ACT_LOAD_NUMBER: begin
				if (number_in_range) begin
					store_d = split_digits;
				end else begin
					ignored_d = 1'b1;
				end
			end
			sssbd_pkg::ACT_LOAD_DIGIT: begin
				store_d[digit_index_s1] = digit_value_s1;
			end
			default: begin
			end
		endcase
	end

	// State and result registers, updated once per item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_q               <= '0;
			scan_pos_q            <= '0;
			blink_pos_q           <= '0;
			scan_elapsed_q        <= '0;
			digit_blink_elapsed_q <= '0;
			whole_blink_elapsed_q <= '0;
			dark_q                <= 1'b0;
			display_on_q          <= 1'b0;
			enable_q              <= sssbd_pkg::ALL_OFF;
			bcd_q                 <= '0;
			ignored_q             <= 1'b0;
		end else if (advance) begin
			store_q               <= store_d;
			scan_pos_q            <= scan_pos_d;
			blink_pos_q           <= blink_pos_d;
			scan_elapsed_q        <= scan_elapsed_d;
			digit_blink_elapsed_q <= digit_blink_elapsed_d;
			whole_blink_elapsed_q <= whole_blink_elapsed_d;
			dark_q                <= dark_d;
			display_on_q          <= display_on_d;
			enable_q              <= enable_d;
			bcd_q                 <= bcd_d;
			ignored_q             <= ignored_d;
		end
	end

	// Result valid: set by a moving item, cleared when the result transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	assign result_valid   = result_valid_q;
	assign digit_enable_n = enable_q;
	assign bcd_code       = bcd_q;
	assign load_ignored   = ignored_q;

	// At most one digit is ever lit.
	assert property (@(posedge clk) disable iff (!arst_n) $onehot0(~enable_q))
		else $error("more than one digit enabled");

	// The BCD pins never carry a value above nine.
	assert property (@(posedge clk) disable iff (!arst_n) bcd_q < sssbd_pkg::BCD_LIMIT)
		else $error("BCD pins out of range");

	// Loads leave the pins untouched.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && action_s1 != sssbd_pkg::ACT_TICK |=> $stable(enable_q) && $stable(bcd_q))
		else $error("load changed the display pins");

	// An out-of-range number load is flagged and leaves the store alone.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && action_s1 == sssbd_pkg::ACT_LOAD_NUMBER && !number_in_range
		|=> load_ignored && $stable(store_q))
		else $error("oversized load not flagged or not ignored");

	// The input stalls only while an item waits in the input stage.
	assert property (@(posedge clk) disable iff (!arst_n) item_stall |-> valid_s1 && result_valid_q)
		else $error("input stalled without a waiting item");

endmodule

>>> dv/seven_segment_scan_blink_driver_unit_tb.sv
module seven_segment_scan_blink_driver_unit_tb;

	// Codes the package leaves out: the spare action and the spare display mode.
	localparam logic [1:0] ACT_UNUSED  = 2'd3;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	// Cycles without any transfer before the run is declared hung.
	localparam int QUIET_LIMIT = 1000;

	// One input item, plus an optional result typed in by hand.
	typedef struct packed {
		logic [1:0] act;
		logic [13:0] num;
		sssbd_pkg::position_t idx;
		sssbd_pkg::bcd_t val;
		logic typed_in;
		sssbd_pkg::enable_t x_en;
		sssbd_pkg::bcd_t x_bcd;
		logic x_ign;
	} stim_row_t;

	// Pin state reported for one item.
	typedef struct packed {
		sssbd_pkg::enable_t en;
		sssbd_pkg::bcd_t bcd;
		logic ignored;
	} pins_t;

	// Directed items. Rows with typed_in set carry their result by hand;
	// the remaining rows go through the predictor.
	localparam stim_row_t DIRECTED [19] = '{
		'{ACT_UNUSED, 14'd16383, 2'd3, 4'd15, 1'b1, sssbd_pkg::ALL_OFF, 4'd0, 1'b0},
		'{sssbd_pkg::ACT_LOAD_NUMBER, 14'd16383, 2'd0, 4'd0, 1'b1, sssbd_pkg::ALL_OFF, 4'd0, 1'b1},
		'{sssbd_pkg::ACT_LOAD_NUMBER, 14'd10000, 2'd0, 4'd0, 1'b1, sssbd_pkg::ALL_OFF, 4'd0, 1'b1},
		'{sssbd_pkg::ACT_LOAD_NUMBER, 14'd9999, 2'd0, 4'd0, 1'b1, sssbd_pkg::ALL_OFF, 4'd0, 1'b0},
		'{sssbd_pkg::ACT_LOAD_NUMBER, 14'd0, 2'd0, 4'd0, 1'b1, sssbd_pkg::ALL_OFF, 4'd0, 1'b0},
		'{sssbd_pkg::ACT_TICK, 14'd0, 2'd0, 4'd0, 1'b1, sssbd_pkg::ALL_OFF, 4'd0, 1'b0},
		'{sssbd_pkg::ACT_TICK, 14'd0, 2'd0, 4'd0, 1'b0, sssbd_pkg::ALL_OFF, 4'd0, 1'b0},
		'{sssbd_pkg::ACT_LOAD_NUMBER, 14'd1234, 2'd0, 4'd0, 1'b0, sssbd_pkg::ALL_OFF, 4'd0, 1'b0},
		'{sssbd_pkg::ACT_LOAD_DIGIT, 14'd0, 2'd3, 4'd15, 1'b0, sssbd_pkg::ALL_OFF, 4'd0, 1'b0},
		'{sssbd_pkg::ACT_LOAD_DIGIT, 14'd0, 2'd0, 4'd9, 1'b0, sssbd_pkg::ALL_OFF, 4'd0, 1'b0},
		'{sssbd_pkg::ACT_LOAD_DIGIT, 14'd0, 2'd1, 4'd0, 1'b0, sssbd_pkg::ALL_OFF, 4'd0, 1'b0},
		'{sssbd_pkg::ACT_TICK, 14'd0, 2'd0, 4'd0, 1'b0, sssbd_pkg::ALL_OFF, 4'd0, 1'b0},
		'{sssbd_pkg::ACT_TICK, 14'd0, 2'd0, 4'd0, 1'b0, sssbd_pkg::ALL_OFF, 4'd0, 1'b0},
		'{sssbd_pkg::ACT_TICK, 14'd0, 2'd0, 4'd0, 1'b0, sssbd_pkg::ALL_OFF, 4'd0, 1'b0},
		'{sssbd_pkg::ACT_TICK, 14'd0, 2'd0, 4'd0, 1'b0, sssbd_pkg::ALL_OFF, 4'd0, 1'b0},
		'{sssbd_pkg::ACT_TICK, 14'd0, 2'd0, 4'd0, 1'b0, sssbd_pkg::ALL_OFF, 4'd0, 1'b0},
		'{sssbd_pkg::ACT_TICK, 14'd0, 2'd0, 4'd0, 1'b0, sssbd_pkg::ALL_OFF, 4'd0, 1'b0},
		'{sssbd_pkg::ACT_TICK, 14'd0, 2'd0, 4'd0, 1'b0, sssbd_pkg::ALL_OFF, 4'd0, 1'b0},
		'{sssbd_pkg::ACT_TICK, 14'd0, 2'd0, 4'd0, 1'b0, sssbd_pkg::ALL_OFF, 4'd0, 1'b0}
	};

	logic clk;
	logic arst_n;
	logic cfg_write_en;
	logic [1:0] cfg_index;
	logic [14:0] cfg_data;
	logic item_valid;
	logic item_stall;
	logic [1:0] action;
	logic [13:0] number;
	logic [1:0] digit_index;
	logic [3:0] digit_value;
	logic result_valid;
	logic result_stall;
	logic [3:0] digit_enable_n;
	logic [3:0] bcd_code;
	logic load_ignored;

	// Predicted display state and its configuration.
	logic [1:0] cfg_mode;
	sssbd_pkg::position_t cfg_selected;
	sssbd_pkg::period_t cfg_scan_period;
	sssbd_pkg::period_t cfg_blink_period;
	sssbd_pkg::bcd_t digit_mem [sssbd_pkg::DIGIT_COUNT];
	sssbd_pkg::position_t scan_pos;
	sssbd_pkg::position_t blink_pos;
	sssbd_pkg::elapsed_t scan_ms;
	sssbd_pkg::elapsed_t digit_blink_ms;
	sssbd_pkg::elapsed_t whole_blink_ms;
	logic blink_dark;
	logic display_lit;
	sssbd_pkg::enable_t pred_en;
	sssbd_pkg::bcd_t pred_bcd;

	// Pin states still owed by the block, oldest first.
	pins_t pending_pins [$];

	int mismatches;
	int results_taken;
	int quiet_cycles;
	bit steady;
	bit held_off;

	seven_segment_scan_blink_driver_unit dut (.*);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Elapsed counters stop at their top value instead of wrapping.
	function automatic sssbd_pkg::elapsed_t count_up(sssbd_pkg::elapsed_t c);
		return (c == sssbd_pkg::COUNT_MAX) ? c : c + 1'b1;
	endfunction

	// Digits above nine leave the BCD pins as they were.
	function automatic void show_digit(sssbd_pkg::bcd_t v);
		if (v < sssbd_pkg::BCD_LIMIT)
			pred_bcd = v;
	endfunction

	// Advance the plain scan by one digit once its period is exceeded.
	function automatic void scan_step();
		if (scan_ms > {1'b0, cfg_scan_period}) begin
			pred_en = sssbd_pkg::ALL_OFF;
			pred_en[scan_pos] = 1'b0;
			show_digit(digit_mem[scan_pos]);
			scan_pos = scan_pos + 1'b1;
			scan_ms = '0;
		end
	endfunction

	// Apply one item to the predicted state and return the pins it reports.
	function automatic pins_t predict_pins(stim_row_t r);
		int n;
		sssbd_pkg::position_t pos;
		pins_t p;
		p.ignored = 1'b0;
		if (r.act == sssbd_pkg::ACT_TICK) begin
			scan_ms = count_up(scan_ms);
			digit_blink_ms = count_up(digit_blink_ms);
			whole_blink_ms = count_up(whole_blink_ms);
			if (cfg_mode == sssbd_pkg::MODE_PLAIN) begin
				scan_step();
			end else if (cfg_mode == sssbd_pkg::MODE_DIGIT_BLINK) begin
				pos = blink_pos;
				show_digit(digit_mem[pos]);
				pred_en = sssbd_pkg::ALL_OFF;
				if (pos == cfg_selected) begin
					if (!blink_dark)
						pred_en[pos] = 1'b0;
					if (digit_blink_ms > {1'b0, cfg_blink_period}) begin
						blink_dark = ~blink_dark;
						digit_blink_ms = '0;
					end
				end else begin
					pred_en[pos] = 1'b0;
				end
				blink_pos = pos + 1'b1;
			end else if (cfg_mode == sssbd_pkg::MODE_WHOLE_BLINK) begin
				if (whole_blink_ms > {1'b0, cfg_blink_period}) begin
					if (display_lit)
						pred_en = sssbd_pkg::ALL_OFF;
					display_lit = ~display_lit;
					whole_blink_ms = '0;
				end
				if (display_lit)
					scan_step();
			end
		end else if (r.act == sssbd_pkg::ACT_LOAD_NUMBER) begin
			if (r.num < sssbd_pkg::NUMBER_LIMIT) begin
				n = r.num;
				for (int i = sssbd_pkg::DIGIT_COUNT - 1; i >= 0; i--) begin
					digit_mem[i] = sssbd_pkg::bcd_t'(n % 10);
					n = n / 10;
				end
			end else begin
				p.ignored = 1'b1;
			end
		end else if (r.act == sssbd_pkg::ACT_LOAD_DIGIT) begin
			digit_mem[r.idx] = r.val;
		end
		p.en = pred_en;
		p.bcd = pred_bcd;
		return p;
	endfunction

	// Offer one item, with random gaps ahead of it, and record what it owes.
	task automatic send_item(stim_row_t r);
		pins_t p;
		while (!steady && $urandom_range(99) < 28) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		action <= r.act;
		number <= r.num;
		digit_index <= r.idx;
		digit_value <= r.val;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		p = predict_pins(r);
		if (r.typed_in)
			p = '{r.x_en, r.x_bcd, r.x_ign};
		pending_pins.push_back(p);
	endtask

	// One register write; the caller lowers the write enable afterwards.
	task automatic write_reg(logic [1:0] idx, logic [14:0] data);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			sssbd_pkg::REG_DISPLAY_MODE: cfg_mode = data[1:0];
			sssbd_pkg::REG_SELECTED_DIGIT: cfg_selected = data[1:0];
			sssbd_pkg::REG_SCAN_PERIOD: cfg_scan_period = data;
			sssbd_pkg::REG_BLINK_HALF_PERIOD: cfg_blink_period = data;
			default: ;
		endcase
	endtask

	// Let the block drain, then load a full configuration.
	task automatic program_display(logic [1:0] mode, sssbd_pkg::position_t sel,
			sssbd_pkg::period_t scan, sssbd_pkg::period_t blink);
		item_valid <= 1'b0;
		while (pending_pins.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		write_reg(sssbd_pkg::REG_DISPLAY_MODE, {13'd0, mode});
		write_reg(sssbd_pkg::REG_SELECTED_DIGIT, {13'd0, sel});
		write_reg(sssbd_pkg::REG_SCAN_PERIOD, scan);
		write_reg(sssbd_pkg::REG_BLINK_HALF_PERIOD, blink);
		cfg_write_en <= 1'b0;
	endtask

	// A phase of random items (or plain ticks) under one configuration.
	task automatic run_phase(logic [1:0] mode, sssbd_pkg::position_t sel,
			sssbd_pkg::period_t scan, sssbd_pkg::period_t blink, int count, bit ticks_only);
		stim_row_t row;
		int pick;
		program_display(mode, sel, scan, blink);
		for (int k = 0; k < count; k++) begin
			row = '0;
			row.act = sssbd_pkg::ACT_TICK;
			if (!ticks_only) begin
				pick = $urandom_range(99);
				// Mostly in-range numbers, but every bit of the field gets exercised.
				row.num = ($urandom_range(3) == 0) ? 14'($urandom) : 14'($urandom_range(9999));
				row.idx = 2'($urandom);
				row.val = ($urandom_range(4) == 0) ? 4'($urandom) : 4'($urandom_range(9));
				if (pick < 60)
					row.act = sssbd_pkg::ACT_TICK;
				else if (pick < 78)
					row.act = sssbd_pkg::ACT_LOAD_NUMBER;
				else if (pick < 95)
					row.act = sssbd_pkg::ACT_LOAD_DIGIT;
				else
					row.act = ACT_UNUSED;
			end
			send_item(row);
		end
	endtask

	// Receiver: check each transfer and stall at random, with one long hold-off
	// that backs the block up into its input.
	initial begin
		pins_t want;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && !result_stall) begin
				results_taken++;
				if (pending_pins.size() == 0) begin
					$error("result transfer with no item outstanding");
					mismatches++;
				end else begin
					want = pending_pins.pop_front();
					if (digit_enable_n !== want.en) begin
						$error("digit_enable_n: expected %b, got %b", want.en, digit_enable_n);
						mismatches++;
					end
					if (bcd_code !== want.bcd) begin
						$error("bcd_code: expected %0d, got %0d", want.bcd, bcd_code);
						mismatches++;
					end
					if (load_ignored !== want.ignored) begin
						$error("load_ignored: expected %b, got %b", want.ignored, load_ignored);
						mismatches++;
					end
				end
			end
			if (!held_off && results_taken == 100) begin
				held_off = 1'b1;
				result_stall <= 1'b1;
				repeat (60) @(posedge clk);
			end
			result_stall <= !steady && $urandom_range(99) < 28;
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("seven_segment_scan_blink_driver_unit_tb failed");
				$finish;
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_write_en <= 1'b0;
		cfg_index <= sssbd_pkg::REG_DISPLAY_MODE;
		cfg_data <= '0;
		item_valid <= 1'b0;
		action <= sssbd_pkg::ACT_TICK;
		number <= '0;
		digit_index <= '0;
		digit_value <= '0;
		result_stall <= 1'b0;

		// The predicted state starts where reset leaves the block.
		cfg_mode = sssbd_pkg::MODE_PLAIN;
		cfg_selected = '0;
		cfg_scan_period = sssbd_pkg::SCAN_PERIOD_RESET;
		cfg_blink_period = sssbd_pkg::BLINK_HALF_PERIOD_RESET;
		foreach (digit_mem[i])
			digit_mem[i] = '0;
		scan_pos = '0;
		blink_pos = '0;
		scan_ms = '0;
		digit_blink_ms = '0;
		whole_blink_ms = '0;
		blink_dark = 1'b0;
		display_lit = 1'b0;
		pred_en = sssbd_pkg::ALL_OFF;
		pred_bcd = '0;
		mismatches = 0;
		results_taken = 0;
		steady = 1'b0;
		held_off = 1'b0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items under a scan period of 1.
		program_display(sssbd_pkg::MODE_PLAIN, 2'd0, 15'd1, sssbd_pkg::BLINK_HALF_PERIOD_RESET);
		foreach (DIRECTED[i])
			send_item(DIRECTED[i]);

		// Random phases across the modes and the extremes of each register.
		run_phase(sssbd_pkg::MODE_PLAIN, 2'd0, 15'd1, 15'd1, 90, 1'b0);
		run_phase(sssbd_pkg::MODE_DIGIT_BLINK, 2'd3, 15'd32767, 15'd1, 90, 1'b0);
		run_phase(sssbd_pkg::MODE_DIGIT_BLINK, 2'($urandom), 15'($urandom_range(1, 4)),
			15'($urandom_range(1, 6)), 90, 1'b0);
		steady = 1'b1;
		run_phase(sssbd_pkg::MODE_WHOLE_BLINK, 2'd1, 15'd1, 15'd2, 90, 1'b0);
		steady = 1'b0;
		run_phase(sssbd_pkg::MODE_WHOLE_BLINK, 2'd2, 15'($urandom_range(1, 3)),
			15'($urandom_range(1, 5)), 90, 1'b0);
		run_phase(MODE_UNUSED, 2'd2, 15'($urandom_range(1, 32767)),
			15'($urandom_range(1, 32767)), 60, 1'b0);
		run_phase(sssbd_pkg::MODE_PLAIN, 2'($urandom), 15'($urandom_range(1, 6)),
			15'($urandom_range(1, 32767)), 90, 1'b0);

		item_valid <= 1'b0;
		while (pending_pins.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("seven_segment_scan_blink_driver_unit_tb passed");
		end else begin
			$display("seven_segment_scan_blink_driver_unit_tb failed");
		end
		$finish;
	end

endmodule

>>> files.f
sv/sssbd_pkg.sv
sv/sssbd_bcd_split.sv
sv/seven_segment_scan_blink_driver_unit.sv
dv/seven_segment_scan_blink_driver_unit_tb.sv
